// File: rtl/core/bptc_pkg.sv
// ----------------------------------------------------------------------------
// bptc_pkg - shared types and constants for barometric compensation
// Calibration bundle, register indexes, pipeline geometry and the
// hand-off record between the temperature and pressure halves.
// ----------------------------------------------------------------------------
package bptc_pkg;

	// pipeline geometry
	localparam int NUM_STG   = 8;
	localparam int FRONT_STG = 4;

	// datapath widths
	localparam int RAW_W  = 24;
	localparam int CAL_W  = 16;
	localparam int DT_W   = 26;
	localparam int PROD_W = 42;
	localparam int DTSQ_W = 48;
	localparam int OFF1_W = 35;
	localparam int SEN1_W = 34;
	localparam int TEMP_W = 20;
	localparam int T2_W   = 17;
	localparam int SQ_W   = 34;
	localparam int OFF_W  = 39;
	localparam int SENS_W = 38;
	localparam int PRES_W = 32;

	// temperature thresholds in 0.01 degC
	localparam logic signed [TEMP_W-1:0] TEMP_BASE = 20'sd2000;
	localparam logic signed [TEMP_W-1:0] TEMP_VLOW = -20'sd1500;

	// calibration register indexes
	typedef enum logic [2:0] {
		REG_C1 = 3'd0,
		REG_C2 = 3'd1,
		REG_C3 = 3'd2,
		REG_C4 = 3'd3,
		REG_C5 = 3'd4,
		REG_C6 = 3'd5
	} reg_idx_t;

	// calibration words
	typedef struct packed {
		logic [CAL_W-1:0] c1;
		logic [CAL_W-1:0] c2;
		logic [CAL_W-1:0] c3;
		logic [CAL_W-1:0] c4;
		logic [CAL_W-1:0] c5;
		logic [CAL_W-1:0] c6;
	} cal_t;

	// first-order results and squares handed to the pressure half
	typedef struct packed {
		logic signed [OFF1_W-1:0] off1;
		logic signed [SEN1_W-1:0] sens1;
		logic [SQ_W-1:0]          sq_a;
		logic [SQ_W-1:0]          sq_b;
		logic                     low;
		logic                     vlow;
		logic [RAW_W-1:0]         d1;
		logic signed [TEMP_W-1:0] temp;
	} mid_t;

endpackage

// File: rtl/core/bptc_ctrl.sv
// ----------------------------------------------------------------------------
// bptc_ctrl - valid tracking and stall handling for the pipeline
// One valid bit per stage; a stage loads when it is empty or its
// successor moves, so bubbles close up under output stall.
// ----------------------------------------------------------------------------
module bptc_ctrl
	import bptc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [NUM_STG-1:0] en
);

	logic [NUM_STG-1:0] vld_q;
	logic [NUM_STG:0]   ready;

	// ready chain, from the output back to the input
	always_comb begin
		ready[NUM_STG] = !out_stall;
		for (int k = NUM_STG - 1; k >= 0; k--) begin
			ready[k] = !vld_q[k] || ready[k+1];
		end
	end

	assign en        = ready[NUM_STG-1:0];
	assign in_stall  = !ready[0];
	assign out_valid = vld_q[NUM_STG-1];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ready[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STG; k++) begin
				if (ready[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	// input only backs up when every stage is full and the output is held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (&vld_q && out_stall))
		else $error("input stalled with room in pipeline");

	// an accepted beat with none delivered adds one to the occupancy
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !(out_valid && !out_stall)) |=>
		($countones(vld_q) == $past($countones(vld_q)) + 1))
		else $error("accepted beat lost in pipeline");

	// a delivered beat with none accepted removes exactly one
	a_count_dn: assert property (@(posedge clk) disable iff (!arst_n)
		(!(in_valid && !in_stall) && out_valid && !out_stall) |=>
		($countones(vld_q) == $past($countones(vld_q)) - 1))
		else $error("delivered beat repeated or lost");
`endif

endmodule

// File: rtl/core/bptc_temp.sv
// ----------------------------------------------------------------------------
// bptc_temp - stages 1 to 4: dT, first-order terms, temperature, squares
// Produces OFF, SENS, the final temperature and the second-order squares.
// ----------------------------------------------------------------------------
module bptc_temp
	import bptc_pkg::*;
(
	input  logic                 clk,
	input  logic [FRONT_STG-1:0] en,
	input  cal_t                 cal,
	input  logic [RAW_W-1:0]     raw_pressure,
	input  logic [RAW_W-1:0]     raw_temperature,
	input  logic                 compensate,
	output mid_t                 mid
);

	// stage 1: dT = D2 - C5*256
	logic signed [DT_W-1:0] dt_s1;
	logic [RAW_W-1:0]       d1_s1;
	logic                   comp_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			dt_s1   <= $signed({2'b00, raw_temperature}) - $signed({2'b00, cal.c5, 8'h00});
			d1_s1   <= raw_pressure;
			comp_s1 <= compensate;
		end
	end

	// stage 2: the four products on dT
	logic signed [PROD_W:0]   c4dt_full;
	logic signed [PROD_W:0]   c3dt_full;
	logic signed [PROD_W:0]   dtc6_full;
	logic signed [2*DT_W-1:0] dtsq_full;

	assign c4dt_full = (PROD_W+1)'($signed({1'b0, cal.c4})) * (PROD_W+1)'(dt_s1);
	assign c3dt_full = (PROD_W+1)'($signed({1'b0, cal.c3})) * (PROD_W+1)'(dt_s1);
	assign dtc6_full = (PROD_W+1)'($signed({1'b0, cal.c6})) * (PROD_W+1)'(dt_s1);
	assign dtsq_full = (2*DT_W)'(dt_s1) * (2*DT_W)'(dt_s1);

	logic signed [PROD_W-1:0] c4dt_s2;
	logic signed [PROD_W-1:0] c3dt_s2;
	logic signed [PROD_W-1:0] dtc6_s2;
	logic [DTSQ_W-1:0]        dtsq_s2;
	logic [RAW_W-1:0]         d1_s2;
	logic                     comp_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			c4dt_s2 <= c4dt_full[PROD_W-1:0];
			c3dt_s2 <= c3dt_full[PROD_W-1:0];
			dtc6_s2 <= dtc6_full[PROD_W-1:0];
			dtsq_s2 <= dtsq_full[DTSQ_W-1:0];
			d1_s2   <= d1_s1;
			comp_s2 <= comp_s1;
		end
	end

	// stage 3: truncating shifts (bias negatives) and first-order sums
	logic signed [PROD_W-1:0] c4b;
	logic signed [PROD_W-1:0] c3b;
	logic signed [PROD_W-1:0] c6b;
	logic signed [OFF1_W-1:0] off1_n;
	logic signed [SEN1_W-1:0] sens1_n;
	logic signed [TEMP_W-1:0] temp_n;

	assign c4b     = c4dt_s2 + $signed({35'd0, {7{c4dt_s2[PROD_W-1]}}});
	assign c3b     = c3dt_s2 + $signed({34'd0, {8{c3dt_s2[PROD_W-1]}}});
	assign c6b     = dtc6_s2 + $signed({19'd0, {23{dtc6_s2[PROD_W-1]}}});
	assign off1_n  = $signed({3'b000, cal.c2, 16'h0000}) + $signed(c4b[PROD_W-1:7]);
	assign sens1_n = $signed({3'b000, cal.c1, 15'h0000}) + $signed(c3b[PROD_W-1:8]);
	assign temp_n  = TEMP_BASE + TEMP_W'($signed(c6b[PROD_W-1:23]));

	logic signed [OFF1_W-1:0] off1_s3;
	logic signed [SEN1_W-1:0] sens1_s3;
	logic signed [TEMP_W-1:0] temp_s3;
	logic [T2_W-1:0]          temp2_s3;
	logic [RAW_W-1:0]         d1_s3;
	logic                     comp_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			off1_s3  <= off1_n;
			sens1_s3 <= sens1_n;
			temp_s3  <= temp_n;
			temp2_s3 <= dtsq_s2[DTSQ_W-1:31];
			d1_s3    <= d1_s2;
			comp_s3  <= comp_s2;
		end
	end

	// stage 4: distances from thresholds, squares, final temperature
	logic signed [TEMP_W-1:0]   a_n;
	logic signed [TEMP_W-1:0]   b_n;
	logic signed [2*TEMP_W-1:0] sqa_full;
	logic signed [2*TEMP_W-1:0] sqb_full;
	logic                       low_n;

	assign a_n      = temp_s3 - TEMP_BASE;
	assign b_n      = temp_s3 - TEMP_VLOW;
	assign sqa_full = (2*TEMP_W)'(a_n) * (2*TEMP_W)'(a_n);
	assign sqb_full = (2*TEMP_W)'(b_n) * (2*TEMP_W)'(b_n);
	assign low_n    = comp_s3 && (temp_s3 < TEMP_BASE);

	mid_t mid_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			mid_s4.off1  <= off1_s3;
			mid_s4.sens1 <= sens1_s3;
			mid_s4.sq_a  <= sqa_full[SQ_W-1:0];
			mid_s4.sq_b  <= sqb_full[SQ_W-1:0];
			mid_s4.low   <= low_n;
			mid_s4.vlow  <= temp_s3 < TEMP_VLOW;
			mid_s4.d1    <= d1_s3;
			mid_s4.temp  <= low_n ? temp_s3 - $signed({3'b000, temp2_s3}) : temp_s3;
		end
	end

	assign mid = mid_s4;

endmodule

// File: rtl/core/bptc_press.sv
// ----------------------------------------------------------------------------
// bptc_press - stages 5 to 8: second-order terms and pressure
// Applies OFF2/SENS2, splits D1*SENS into two partial products and
// finishes P = (D1*SENS/2^21 - OFF)/2^15 with truncation toward zero.
// ----------------------------------------------------------------------------
module bptc_press
	import bptc_pkg::*;
(
	input  logic                         clk,
	input  logic [NUM_STG-FRONT_STG-1:0] en,
	input  mid_t                         mid,
	output logic signed [PRES_W-1:0]     pressure,
	output logic signed [TEMP_W-1:0]     temperature
);

	// stage 5: OFF2 = 5a^2/2 (+7b^2), SENS2 = 5a^2/4 (+11b^2/2)
	logic [SQ_W+2:0] fa;
	logic [SQ_W+2:0] b7;
	logic [SQ_W+3:0] b11;
	logic [SQ_W+3:0] off2;
	logic [SQ_W+2:0] sens2;
	logic signed [OFF_W-1:0]  off_n;
	logic signed [SENS_W-1:0] sens_n;

	assign fa    = {3'b000, mid.sq_a} + {1'b0, mid.sq_a, 2'b00};
	assign b7    = {mid.sq_b, 3'b000} - {3'b000, mid.sq_b};
	assign b11   = {1'b0, mid.sq_b, 3'b000} + {3'b000, mid.sq_b, 1'b0} + {4'h0, mid.sq_b};
	assign off2  = {2'b00, fa[SQ_W+2:1]} + (mid.vlow ? {1'b0, b7} : '0);
	assign sens2 = {2'b00, fa[SQ_W+2:2]} + (mid.vlow ? b11[SQ_W+3:1] : '0);
	assign off_n  = $signed({{4{mid.off1[OFF1_W-1]}}, mid.off1})
		- (mid.low ? $signed({1'b0, off2}) : 39'sd0);
	assign sens_n = $signed({{4{mid.sens1[SEN1_W-1]}}, mid.sens1})
		- (mid.low ? $signed({1'b0, sens2}) : 38'sd0);

	logic signed [OFF_W-1:0]  off_s5;
	logic signed [SENS_W-1:0] sens_s5;
	logic [RAW_W-1:0]         d1_s5;
	logic signed [TEMP_W-1:0] temp_s5;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			off_s5  <= off_n;
			sens_s5 <= sens_n;
			d1_s5   <= mid.d1;
			temp_s5 <= mid.temp;
		end
	end

	// stage 6: D1 times the low and high halves of SENS
	logic [42:0]        lo_full;
	logic signed [43:0] hi_full;

	assign lo_full = 43'(d1_s5) * 43'(sens_s5[18:0]);
	assign hi_full = 44'($signed({1'b0, d1_s5})) * 44'($signed(sens_s5[SENS_W-1:19]));

	logic [42:0]              lo_s6;
	logic signed [42:0]       hi_s6;
	logic signed [OFF_W-1:0]  off_s6;
	logic signed [TEMP_W-1:0] temp_s6;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			lo_s6   <= lo_full;
			hi_s6   <= hi_full[42:0];
			off_s6  <= off_s5;
			temp_s6 <= temp_s5;
		end
	end

	// stage 7: recombine, then divide by 2^21 toward zero
	logic signed [61:0] prod;
	logic signed [61:0] pb;

	assign prod = $signed({hi_s6, 19'd0}) + $signed({19'd0, lo_s6});
	assign pb   = prod + $signed({41'd0, {21{prod[61]}}});

	logic signed [40:0]       q_s7;
	logic signed [OFF_W-1:0]  off_s7;
	logic signed [TEMP_W-1:0] temp_s7;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			q_s7    <= pb[61:21];
			off_s7  <= off_s6;
			temp_s7 <= temp_s6;
		end
	end

	// stage 8: subtract OFF, divide by 2^15 toward zero
	logic signed [41:0] dif;
	logic signed [41:0] db;

	assign dif = $signed({q_s7[40], q_s7}) - $signed({{3{off_s7[OFF_W-1]}}, off_s7});
	assign db  = dif + $signed({27'd0, {15{dif[41]}}});

	logic signed [PRES_W-1:0] pressure_s8;
	logic signed [TEMP_W-1:0] temperature_s8;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			pressure_s8    <= $signed({{5{db[41]}}, db[41:15]});
			temperature_s8 <= temp_s7;
		end
	end

	assign pressure    = pressure_s8;
	assign temperature = temperature_s8;

endmodule

// File: rtl/core/baro_pressure_temp_compensation.sv
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation - second-order pressure/temperature fix-up
// Throughput: one beat per cycle while the output is not stalled; the D1*SENS
// product is split into two partial products over stages 6 and 7, which sets
// the depth.
// Reset: clears the stage valid bits and the six calibration words to zero.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation
	import bptc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// calibration write channel
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [2:0]               cfg_index,
	input  logic [CAL_W-1:0]         cfg_data,
	// input samples
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [RAW_W-1:0]         raw_pressure,
	input  logic [RAW_W-1:0]         raw_temperature,
	input  logic                     compensate,
	// results
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [PRES_W-1:0] pressure,
	output logic signed [TEMP_W-1:0] temperature
);

	cal_t               cal_q;
	logic [NUM_STG-1:0] en;
	mid_t               mid;

	assign cfg_ready = 1'b1;

	// calibration registers; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_C1: cal_q.c1 <= cfg_data;
				REG_C2: cal_q.c2 <= cfg_data;
				REG_C3: cal_q.c3 <= cfg_data;
				REG_C4: cal_q.c4 <= cfg_data;
				REG_C5: cal_q.c5 <= cfg_data;
				REG_C6: cal_q.c6 <= cfg_data;
				default: ;
			endcase
		end
	end

	bptc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.en        (en)
	);

	bptc_temp u_temp (
		.clk             (clk),
		.en              (en[FRONT_STG-1:0]),
		.cal             (cal_q),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.compensate      (compensate),
		.mid             (mid)
	);

	bptc_press u_press (
		.clk         (clk),
		.en          (en[NUM_STG-1:FRONT_STG]),
		.mid         (mid),
		.pressure    (pressure),
		.temperature (temperature)
	);

endmodule

// File: verif/baro_pressure_temp_compensation_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_test - self-checking bench for compensation
// Loads calibration sets and streams raw pressure/temperature pairs through
// the block. Runs a directed table first, then random phases with fresh
// calibration. Each result beat is checked against a local model of the
// first- and second-order compensation math.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_test
	import bptc_pkg::*;
();

	localparam int     LATENCY      = NUM_STG;
	localparam int     LONG_HOLD    = 48;
	localparam int     RAND_PHASES  = 8;
	localparam int     PHASE_ITEMS  = 125;
	localparam int     MAX_PRINTED  = 50;
	localparam longint RUN_LIMIT_NS = 3_000_000;
	localparam longint DT_SQ_SCALE  = 64'sd2147483648;

	// register indexes past the last calibration word
	localparam logic [2:0] IDX_SPARE_LO = 3'd6;
	localparam logic [2:0] IDX_SPARE_HI = 3'd7;

	// calibration sets used by the directed table
	localparam logic [1:0] CAL_RESET   = 2'd0;
	localparam logic [1:0] CAL_TYPICAL = 2'd1;
	localparam logic [1:0] CAL_MAX     = 2'd2;

	localparam cal_t TYPICAL_CAL = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317,
		c4: 16'd23282, c5: 16'd33464, c6: 16'd28312};
	localparam cal_t ALL_MAX_CAL = '1;

	typedef struct packed {
		logic [PRES_W-1:0] pressure;
		logic [TEMP_W-1:0] temperature;
	} reading_t;

	// with all calibration words zero: no sensitivity, no offset, 20.00 degC
	localparam reading_t AT_RESET_READING = '{pressure: 32'd0, temperature: 20'd2000};

	typedef struct packed {
		logic [1:0]       cal_set;
		logic [RAW_W-1:0] d1;
		logic [RAW_W-1:0] d2;
		logic             comp;
		logic             typed;
		reading_t         want;
	} sample_row_t;

	localparam int N_DIRECTED = 21;

	sample_row_t directed_rows [N_DIRECTED] = '{
		// zero calibration straight out of reset
		'{CAL_RESET,   24'd0,        24'd0,        1'b0, 1'b1, AT_RESET_READING},
		'{CAL_RESET,   24'hFFFFFF,   24'hFFFFFF,   1'b1, 1'b1, AT_RESET_READING},
		'{CAL_RESET,   24'hFFFFFF,   24'd0,        1'b1, 1'b1, AT_RESET_READING},
		'{CAL_RESET,   24'd0,        24'hFFFFFF,   1'b0, 1'b1, AT_RESET_READING},
		// typical part: nominal conversion, then both temperature thresholds
		'{CAL_TYPICAL, 24'd9085466,  24'd8569150,  1'b0, 1'b0, '0},
		'{CAL_TYPICAL, 24'd9085466,  24'd8569150,  1'b1, 1'b0, '0},
		'{CAL_TYPICAL, 24'd9085466,  24'd8566784,  1'b1, 1'b0, '0},
		'{CAL_TYPICAL, 24'd9085466,  24'd8566488,  1'b1, 1'b0, '0},
		'{CAL_TYPICAL, 24'd9085466,  24'd8566487,  1'b1, 1'b0, '0},
		'{CAL_TYPICAL, 24'd9085466,  24'd7529468,  1'b1, 1'b0, '0},
		'{CAL_TYPICAL, 24'd9085466,  24'd7529467,  1'b1, 1'b0, '0},
		'{CAL_TYPICAL, 24'd9085466,  24'd7529467,  1'b0, 1'b0, '0},
		'{CAL_TYPICAL, 24'd0,        24'd0,        1'b1, 1'b0, '0},
		'{CAL_TYPICAL, 24'hFFFFFF,   24'd0,        1'b1, 1'b0, '0},
		'{CAL_TYPICAL, 24'hFFFFFF,   24'hFFFFFF,   1'b1, 1'b0, '0},
		'{CAL_TYPICAL, 24'd0,        24'hFFFFFF,   1'b0, 1'b0, '0},
		// every word at full scale: deepest cold corrections
		'{CAL_MAX,     24'hFFFFFF,   24'd0,        1'b1, 1'b0, '0},
		'{CAL_MAX,     24'hFFFFFF,   24'd0,        1'b0, 1'b0, '0},
		'{CAL_MAX,     24'd0,        24'd0,        1'b1, 1'b0, '0},
		'{CAL_MAX,     24'hFFFFFF,   24'hFFFFFF,   1'b1, 1'b0, '0},
		'{CAL_MAX,     24'h800000,   24'h7FFFFF,   1'b1, 1'b0, '0}
	};

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [2:0]               cfg_index;
	logic [CAL_W-1:0]         cfg_data;
	logic                     in_valid;
	logic                     in_stall;
	logic [RAW_W-1:0]         raw_pressure;
	logic [RAW_W-1:0]         raw_temperature;
	logic                     compensate;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [PRES_W-1:0] pressure;
	logic signed [TEMP_W-1:0] temperature;

	cal_t     cal_mirror;
	reading_t readings_due [$];
	int       mismatch_count = 0;
	bit       gaps_on        = 1'b1;
	bit       stalls_on      = 1'b1;
	bit       hold_request   = 1'b0;
	bit       offering       = 1'b0;

	baro_pressure_temp_compensation u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.compensate      (compensate),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pressure        (pressure),
		.temperature     (temperature)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#(RUN_LIMIT_NS);
		$display("baro_pressure_temp_compensation: mismatch");
		$finish;
	end

	task automatic note_mismatch(input string what);
		if (mismatch_count < MAX_PRINTED)
			$display("ERROR @%0t: %s", $time, what);
		mismatch_count++;
	endtask

	// compensated pressure and temperature for one sample pair
	function automatic reading_t compensated_reading(input logic [RAW_W-1:0] d1,
			input logic [RAW_W-1:0] d2, input logic comp);
		longint   c1, c2, c3, c4, c5, c6;
		longint   d1v, dt, off, sens, temp, temp2, a, b, off2, sens2, p, t;
		reading_t r;
		c1 = longint'(cal_mirror.c1);
		c2 = longint'(cal_mirror.c2);
		c3 = longint'(cal_mirror.c3);
		c4 = longint'(cal_mirror.c4);
		c5 = longint'(cal_mirror.c5);
		c6 = longint'(cal_mirror.c6);
		d1v = longint'(d1);
		dt = longint'(d2);
		dt = dt - c5 * 256;
		// first order
		off = c2 * 65536 + (c4 * dt) / 128;
		sens = c1 * 32768 + (c3 * dt) / 256;
		temp = longint'(TEMP_BASE) + (dt * c6) / 8388608;
		temp2 = 0;
		// second order below 20.00 degC, extra term below -15.00 degC
		if (comp && temp < longint'(TEMP_BASE)) begin
			a = temp - longint'(TEMP_BASE);
			off2 = 5 * (a * a) / 2;
			sens2 = 5 * (a * a) / 4;
			if (temp < longint'(TEMP_VLOW)) begin
				b = temp - longint'(TEMP_VLOW);
				off2 = off2 + 7 * (b * b);
				sens2 = sens2 + 11 * (b * b) / 2;
			end
			off = off - off2;
			sens = sens - sens2;
			temp2 = (dt * dt) / DT_SQ_SCALE;
		end
		p = (d1v * sens / 2097152 - off) / 32768;
		t = temp - temp2;
		r.pressure = p[PRES_W-1:0];
		r.temperature = t[TEMP_W-1:0];
		return r;
	endfunction

	// one calibration write; caller lowers cfg_valid after the last one
	task automatic write_reg(input logic [2:0] idx, input logic [CAL_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_C1: cal_mirror.c1 = val;
			REG_C2: cal_mirror.c2 = val;
			REG_C3: cal_mirror.c3 = val;
			REG_C4: cal_mirror.c4 = val;
			REG_C5: cal_mirror.c5 = val;
			REG_C6: cal_mirror.c6 = val;
			default: ;
		endcase
	endtask

	// all six words, then junk to the unused indexes, which must not land
	task automatic load_calibration(input cal_t cs);
		write_reg(REG_C1, cs.c1);
		write_reg(REG_C2, cs.c2);
		write_reg(REG_C3, cs.c3);
		write_reg(REG_C4, cs.c4);
		write_reg(REG_C5, cs.c5);
		write_reg(REG_C6, cs.c6);
		write_reg(IDX_SPARE_LO, CAL_W'($urandom));
		write_reg(IDX_SPARE_HI, CAL_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// lower valid and step past the edge so the next raise is in a later step
	task automatic drop_valid();
		if (offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic offer_sample(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2,
			input logic comp, input logic typed, input reading_t typed_want);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			drop_valid();
			repeat ($urandom_range(0, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_pressure <= d1;
		raw_temperature <= d2;
		compensate <= comp;
		offering = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		readings_due.push_back(typed ? typed_want : compensated_reading(d1, d2, comp));
	endtask

	// sender stops until every result is back
	task automatic wait_drained();
		drop_valid();
		while (readings_due.size() != 0) @(posedge clk);
	endtask

	function automatic logic [CAL_W-1:0] pick_cal_word(input logic [CAL_W-1:0] typical);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2, 3: return CAL_W'($urandom);
			default: return typical + CAL_W'($urandom_range(0, 511)) - 16'd256;
		endcase
	endfunction

	// result side: random stall bursts, plus one long hold on request
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
				hold_request = 1'b0;
			end else if (stalls_on && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// compare each result beat with the oldest reading due
	always @(posedge clk) begin : check_results
		reading_t due;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (readings_due.size() == 0) begin
				note_mismatch($sformatf("result beat with nothing due: p=%0d t=%0d",
					pressure, temperature));
			end else begin
				due = readings_due.pop_front();
				if (pressure !== due.pressure)
					note_mismatch($sformatf("pressure: got %0d want %0d",
						pressure, $signed(due.pressure)));
				if (temperature !== due.temperature)
					note_mismatch($sformatf("temperature: got %0d want %0d",
						temperature, $signed(due.temperature)));
			end
		end
	end

	// stimulus
	initial begin
		logic [1:0]       cur_set;
		logic [RAW_W-1:0] d1;
		logic [RAW_W-1:0] d2;
		logic             comp;
		cal_t             next_cal;
		int               ref_code;
		int               v;
		int               pick;
		bit               last_phase;

		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		raw_pressure <= '0;
		raw_temperature <= '0;
		compensate <= 1'b0;
		cal_mirror = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, reloading calibration when the set changes
		cur_set = CAL_RESET;
		for (int i = 0; i < N_DIRECTED; i++) begin
			if (directed_rows[i].cal_set != cur_set) begin
				wait_drained();
				cur_set = directed_rows[i].cal_set;
				load_calibration(cur_set == CAL_TYPICAL ? TYPICAL_CAL : ALL_MAX_CAL);
			end
			offer_sample(directed_rows[i].d1, directed_rows[i].d2, directed_rows[i].comp,
				directed_rows[i].typed, directed_rows[i].want);
		end

		// random phases, each with its own calibration
		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			wait_drained();
			next_cal.c1 = pick_cal_word(TYPICAL_CAL.c1);
			next_cal.c2 = pick_cal_word(TYPICAL_CAL.c2);
			next_cal.c3 = pick_cal_word(TYPICAL_CAL.c3);
			next_cal.c4 = pick_cal_word(TYPICAL_CAL.c4);
			next_cal.c5 = pick_cal_word(TYPICAL_CAL.c5);
			next_cal.c6 = pick_cal_word(TYPICAL_CAL.c6);
			load_calibration(next_cal);
			last_phase = (phase == RAND_PHASES - 1);
			// in phase 2 the sink holds off while the source keeps offering
			if (phase == 2)
				hold_request = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i % 40 == 0) begin
					gaps_on = !last_phase && phase != 2 && $urandom_range(0, 2) != 0;
					stalls_on = !last_phase && $urandom_range(0, 2) != 0;
				end
				ref_code = int'(cal_mirror.c5) * 256;
				pick = $urandom_range(0, 9);
				d1 = RAW_W'($urandom);
				if (pick == 0)
					d1 = $urandom_range(0, 1) ? '1 : '0;
				case (pick)
					6: begin
						// close to the reference: around the 20.00 degC line
						v = ref_code + int'($urandom_range(0, 4095)) - 2048;
						if (v < 0)
							v = 0;
						if (v > 24'hFFFFFF)
							v = 24'hFFFFFF;
						d2 = RAW_W'(v);
					end
					7: d2 = $urandom_range(0, 1) ? '1 : '0;
					8, 9: begin
						// colder than the reference
						if (ref_code > 0)
							d2 = RAW_W'($urandom_range(0, ref_code - 1));
						else
							d2 = RAW_W'($urandom);
					end
					default: d2 = RAW_W'($urandom);
				endcase
				comp = $urandom_range(0, 3) != 0;
				offer_sample(d1, d2, comp, 1'b0, '0);
			end
		end

		// wind down
		drop_valid();
		while (readings_due.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		if (mismatch_count == 0)
			$display("baro_pressure_temp_compensation: match");
		else
			$display("baro_pressure_temp_compensation: mismatch");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/bptc_pkg.sv
rtl/core/bptc_ctrl.sv
rtl/core/bptc_temp.sv
rtl/core/bptc_press.sv
rtl/core/baro_pressure_temp_compensation.sv
verif/baro_pressure_temp_compensation_test.sv
